// File: src/trial_division_prime_test_top_defines.svh
// ----------------------------------------------------------------------------
// Trial division prime test - assertion macros
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_TEST_TOP_DEFINES_SVH

// Same-cycle implication.
`define TDPT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define TDPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/tdpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test - package
// Widths and the sequencer state type shared by the design files.
// ----------------------------------------------------------------------------
package tdpt_pkg;

   // Width of the tested value, two's complement.
   localparam int VALUE_WIDTH = 32;
   // Magnitude bits of a non-negative value.
   localparam int MAG_WIDTH   = VALUE_WIDTH - 1;
   // Trial divisor width: covers sqrt of the largest magnitude plus one step.
   localparam int DIV_WIDTH   = VALUE_WIDTH / 2 + 1;
   // Bit counter for one serial remainder pass.
   localparam int CNT_WIDTH   = $clog2(MAG_WIDTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE
   } state_type;

endpackage

// File: src/trial_division_prime_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test - top level
// Answers whether a signed integer is prime by serial trial division.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low. The answer comes back
// as a one-cycle strobe on rsp_valid with rsp_is_prime; the receiver cannot
// stall it, so it must take the beat in that cycle. Negative values, zero, one
// and even values above two answer in the cycle after acceptance, as do two and
// three. Odd values run trial divisors 3, 5, 7, ... while divisor squared does
// not exceed the value; each divisor costs one bound check state plus a
// bit-serial restoring remainder over MAG_WIDTH (31) dividend bits. The worst
// case, a large 31-bit prime, tries about 23170 divisors, and the serial
// remainder unit dominates its run time. busy is high while trial division
// runs and drops in the strobe cycle; values answered at once never raise it.
// A new beat may be offered in the strobe cycle.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
   import tdpt_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   output logic                          rsp_is_prime
);

   localparam logic [CNT_WIDTH-1:0]   CNT_LAST = CNT_WIDTH'(MAG_WIDTH - 1);
   localparam logic [DIV_WIDTH-1:0]   DIV_STEP = DIV_WIDTH'(2);
   localparam logic [DIV_WIDTH-1:0]   DIV_FIRST = DIV_WIDTH'(3);
   localparam logic [VALUE_WIDTH-1:0] SQ_FIRST = VALUE_WIDTH'(9);
   localparam logic [VALUE_WIDTH-1:0] SQ_FOUR = VALUE_WIDTH'(4);
   localparam logic [MAG_WIDTH-1:0]   MAG_TWO = MAG_WIDTH'(2);
   localparam logic [MAG_WIDTH-1:0]   MAG_FOUR = MAG_WIDTH'(4);

   // Control state.
   state_type              state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;

   // Working registers.
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;     // value under test
   logic [DIV_WIDTH-1:0]   div_ff, div_in;     // current trial divisor
   logic [VALUE_WIDTH-1:0] sq_ff, sq_in;       // div_ff squared
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;     // partial remainder
   logic [MAG_WIDTH-1:0]   shift_ff, shift_in; // dividend bits, MSB first
   logic                   prime_ff, prime_in;

   // Serial remainder step.
   logic [DIV_WIDTH:0]     trial;
   logic                   trial_fits;
   logic [DIV_WIDTH-1:0]   rem_step;
   logic [MAG_WIDTH-1:0]   req_mag;

   assign req_mag    = req_value[MAG_WIDTH-1:0];
   assign trial      = {rem_ff, shift_ff[MAG_WIDTH-1]};
   assign trial_fits = (trial >= {1'b0, div_ff});
   assign rem_step   = trial_fits ? DIV_WIDTH'(trial - {1'b0, div_ff})
                                  : trial[DIV_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      div_ff   <= div_in;
      sq_ff    <= sq_in;
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
      prime_ff <= prime_in;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = 1'b0;
      cnt_in       = cnt_ff;
      mag_in       = mag_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      shift_in     = shift_ff;
      prime_in     = prime_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mag_in = req_mag;
               div_in = DIV_FIRST;
               sq_in  = SQ_FIRST;
               // Settle negatives, small values and even values at once.
               priority if (req_value[VALUE_WIDTH-1] || req_mag < MAG_TWO) begin
                  prime_in     = 1'b0;
                  rsp_valid_in = 1'b1;
               end else if (req_mag < MAG_FOUR) begin
                  prime_in     = 1'b1;
                  rsp_valid_in = 1'b1;
               end else if (!req_mag[0]) begin
                  prime_in     = 1'b0;
                  rsp_valid_in = 1'b1;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end

         ST_CHECK: begin
            // Divisor squared past the value: no factor left to find.
            if (sq_ff > {1'b0, mag_ff}) begin
               prime_in     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               rem_in   = '0;
               shift_in = mag_ff;
               cnt_in   = '0;
               state_in = ST_DIVIDE;
            end
         end

         ST_DIVIDE: begin
            rem_in   = rem_step;
            shift_in = shift_ff << 1;
            cnt_in   = cnt_ff + CNT_WIDTH'(1);
            if (cnt_ff == CNT_LAST) begin
               if (rem_step == '0) begin
                  prime_in     = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  // (i + 2)^2 = i^2 + 4i + 4
                  div_in   = div_ff + DIV_STEP;
                  sq_in    = sq_ff + VALUE_WIDTH'({div_ff, 2'b00}) + SQ_FOUR;
                  state_in = ST_CHECK;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = prime_ff;

endmodule

// File: src/tdpt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trial division prime test - port checker
// Watches the top level's ports for request and answer ordering, and for low values answering not prime.
// ----------------------------------------------------------------------------
`include "trial_division_prime_test_top_defines.svh"

module tdpt_checker
   import tdpt_pkg::*;
(
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic signed [VALUE_WIDTH-1:0] req_value,
   input logic                          rsp_valid,
   input logic                          rsp_is_prime
);

   logic value_low;

   // Values below two never answer prime.
   assign value_low = req_value[VALUE_WIDTH-1] || (req_value < VALUE_WIDTH'(2));

   // An accepted beat either keeps the block busy or answers next cycle.
   `TDPT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_valid, "accepted beat lost")
   // The answer strobe only shows once the block has gone idle.
   `TDPT_ASSERT_IMPLY(a_strobe_idle, rsp_valid, !busy, "answer while busy")
   // No answer without a beat in flight.
   `TDPT_ASSERT_NEXT(a_no_spurious, !busy && !start, !rsp_valid, "spurious answer")
   // Busy drops only with an answer.
   `TDPT_ASSERT_IMPLY(a_done_strobe, $fell(busy) && !$past(reset), rsp_valid, "busy fell silently")
   // Negative values, zero and one answer not prime.
   `TDPT_ASSERT_NEXT(a_low_not_prime, start && !busy && value_low, rsp_valid && !rsp_is_prime, "low value")

endmodule

bind trial_division_prime_test_top tdpt_checker u_tdpt_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_value    (req_value),
   .rsp_valid    (rsp_valid),
   .rsp_is_prime (rsp_is_prime)
);
